[rtl/core/bff_pkg.sv]
// shared types and constants for the byte fir filter
`timescale 1ns / 1ps
`default_nettype none
package bff_pkg;

  localparam int unsigned SAMPLE_W  = 8;
  localparam int unsigned COEF_W    = 8;
  localparam int unsigned MAX_TAPS  = 16;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_LOW  = 4'd0,
    REG_COEF_HIGH = 4'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                block_end;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] filtered;
    logic                out_end;
  } out_item_t;

  typedef struct packed {
    logic advance;
    logic clear;
  } cell_ctrl_t;

endpackage
`default_nettype wire

[rtl/core/bff_tap_cell.sv]
// one tap of the fir chain: holds a delayed sample and forms its product
`timescale 1ns / 1ps
`default_nettype none
module bff_tap_cell (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire bff_pkg::cell_ctrl_t          ctrl,
  input  wire logic [bff_pkg::SAMPLE_W-1:0] sample_in,
  input  wire logic [bff_pkg::COEF_W-1:0]   coef,
  output logic      [bff_pkg::SAMPLE_W-1:0] sample_r,
  output logic      [bff_pkg::SAMPLE_W-1:0] prod
);
  import bff_pkg::*;

  logic [SAMPLE_W+COEF_W-1:0] prod_full;
  logic [SAMPLE_W-1:0]        sample_nxt;

  assign prod_full = {{SAMPLE_W{1'b0}}, coef} * {{COEF_W{1'b0}}, sample_r};
  assign prod      = prod_full[SAMPLE_W-1:0];

  always_comb begin
    sample_nxt = sample_r;
    if (ctrl.advance) begin
      if (ctrl.clear) begin
        sample_nxt = '0;
      end else begin
        sample_nxt = sample_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_r <= '0;
    end else begin
      sample_r <= sample_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/core/bff_out_skid.sv]
// two-entry output buffer that decouples the result channel
`timescale 1ns / 1ps
`default_nettype none
module bff_out_skid (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push_valid,
  input  wire bff_pkg::out_item_t  push_data,
  output logic                     push_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output bff_pkg::out_item_t       out_data
);
  import bff_pkg::*;

  logic      main_valid_r, main_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_item_t main_r, main_nxt;
  out_item_t skid_r, skid_nxt;
  logic      pop;
  logic      push;

  assign push_ready = !skid_valid_r;
  assign out_valid  = main_valid_r;
  assign out_data   = main_r;
  assign pop        = main_valid_r && out_ready;
  assign push       = push_valid && !skid_valid_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (pop) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || pop) begin
        main_nxt       = push_data;
        main_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = push_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      main_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule
`default_nettype wire

[rtl/core/byte_fir_filter.sv]
// byte_fir_filter: causal fir filter over 8-bit samples, result modulo 256
//
// samples enter on the in_ channel (valid/ready), one result per sample
// leaves on the out_ channel. coefficients are written over the cfg_ channel:
// index 0 holds coefficients 0..7, index 1 holds 8..15, byte 0 in bits 7:0.
// cfg_ready is always high; other indexes are ignored.
// the filter is a chain of TAPS-1 cells, each holding one delayed sample and
// handing it to its neighbor on every input transfer; the products of all
// taps with the current coefficients are summed by an adder tree.
// each result is registered in the output buffer and reaches out_ from there.
// throughput: one sample per cycle, unless a full output buffer drops in_ready.
// a transfer with block_end set passes the flag to out_end and zeroes the
// delay line, so the next block starts from an empty history.
// a two-entry output buffer keeps in_ready high while one result waits;
// in_ready drops only when two results are held by a stalled receiver.
// reset (rst_n low, synchronous) clears coefficients, history and buffer.
`timescale 1ns / 1ps
`default_nettype none
module byte_fir_filter #(
  parameter int unsigned TAPS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire bff_pkg::in_item_t              in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output bff_pkg::out_item_t                  out_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [bff_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bff_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bff_pkg::*;

  logic [CFG_DATA_W-1:0]   coef_low_r, coef_low_nxt;
  logic [CFG_DATA_W-1:0]   coef_high_r, coef_high_nxt;
  logic [2*CFG_DATA_W-1:0] coef_all;
  logic [SAMPLE_W-1:0]     tap_line [MAX_TAPS];
  logic [SAMPLE_W-1:0]     tap_prod [MAX_TAPS];
  logic [SAMPLE_W-1:0]     sum_node [1:2*MAX_TAPS-1];
  logic [SAMPLE_W+COEF_W-1:0] prod0;
  logic                    history_empty;
  cell_ctrl_t              ctrl;
  logic                    in_xfer;
  out_item_t               result;

  assign cfg_ready = 1'b1;

  always_comb begin
    coef_low_nxt  = coef_low_r;
    coef_high_nxt = coef_high_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_COEF_LOW:  coef_low_nxt  = cfg_data;
        REG_COEF_HIGH: coef_high_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_low_r  <= '0;
      coef_high_r <= '0;
    end else begin
      coef_low_r  <= coef_low_nxt;
      coef_high_r <= coef_high_nxt;
    end
  end

  assign coef_all     = {coef_high_r, coef_low_r};
  assign in_xfer      = in_valid && in_ready;
  assign ctrl.advance = in_xfer;
  assign ctrl.clear   = in_data.block_end;

  // tap 0 works on the current sample
  assign tap_line[0] = in_data.sample;
  assign prod0 = {{SAMPLE_W{1'b0}}, coef_all[COEF_W-1:0]} *
                 {{COEF_W{1'b0}}, in_data.sample};
  assign tap_prod[0] = prod0[SAMPLE_W-1:0];

  for (genvar j = 1; j < MAX_TAPS; j++) begin : g_tap
    if (j < TAPS) begin : g_cell
      bff_tap_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .sample_in (tap_line[j-1]),
        .coef      (coef_all[j*COEF_W +: COEF_W]),
        .sample_r  (tap_line[j]),
        .prod      (tap_prod[j])
      );
    end else begin : g_unused
      assign tap_line[j] = '0;
      assign tap_prod[j] = '0;
    end
  end

  // adder tree over the tap products
  always_comb begin
    for (int k = 0; k < MAX_TAPS; k++) begin
      sum_node[MAX_TAPS+k] = tap_prod[k];
    end
    for (int k = MAX_TAPS-1; k >= 1; k--) begin
      sum_node[k] = sum_node[2*k] + sum_node[2*k+1];
    end
  end

  always_comb begin
    history_empty = 1'b1;
    for (int k = 1; k < MAX_TAPS; k++) begin
      if (tap_line[k] != '0) begin
        history_empty = 1'b0;
      end
    end
  end

  assign result.filtered = sum_node[1];
  assign result.out_end  = in_data.block_end;

  bff_out_skid u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_data  (result),
    .push_ready (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

`ifndef ASSERT_OFF
  a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output buffer");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> out_valid)
    else $error("no result after input transfer");

  a_block_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_data.block_end) |=> history_empty)
    else $error("history not cleared after block end");
`endif

endmodule
`default_nettype wire

[verif/byte_fir_filter_tb.sv]
// self-checking testbench for byte_fir_filter: directed and random sample streams
`timescale 1ns / 1ps
module byte_fir_filter_tb;
  import bff_pkg::*;

  localparam int TAPS = MAX_TAPS;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_LIMIT = 2000;
  localparam int unsigned RANDOM_SAMPLES = 1350;
  localparam int unsigned PHASE_SAMPLES = 150;
  localparam int unsigned MAX_REPORTS = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [CFG_DATA_W-1:0] coef_words [2];
  logic [SAMPLE_W-1:0] history [MAX_TAPS-1];
  out_item_t filtered_q [$];
  bit in_gaps = 1'b1;
  bit out_stalls = 1'b1;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  byte_fir_filter #(
    .TAPS(TAPS)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[byte_fir_filter] ERROR");
      $finish;
    end
  end

  // direct-form filter over the sample history, newest sample first
  function automatic out_item_t compute_filtered(input in_item_t item);
    out_item_t res;
    logic [SAMPLE_W-1:0] acc;
    logic [COEF_W-1:0] coef;
    int j;
    acc = coef_words[REG_COEF_LOW][COEF_W-1:0] * item.sample;
    for (j = 1; j < TAPS; j++) begin
      coef = coef_words[j / 8][(j % 8) * COEF_W +: COEF_W];
      acc += coef * history[j - 1];
    end
    res.filtered = acc;
    res.out_end = item.block_end;
    if (item.block_end) begin
      for (j = 0; j < MAX_TAPS - 1; j++) history[j] = '0;
    end else if (TAPS > 1) begin
      for (j = TAPS - 2; j >= 1; j--) history[j] = history[j - 1];
      history[0] = item.sample;
    end
    return res;
  endfunction

  task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic last);
    int unsigned gap;
    in_item_t item;
    gap = in_gaps ? $urandom_range(0, 7) : 0;
    item.sample = value;
    item.block_end = last;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    filtered_q.insert(filtered_q.size(), compute_filtered(item));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // leaves cfg_valid high; the caller lowers it after its last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (index == REG_COEF_LOW) begin
      coef_words[REG_COEF_LOW] = value;
    end else if (index == REG_COEF_HIGH) begin
      coef_words[REG_COEF_HIGH] = value;
    end
  endtask

  task automatic load_coefs(input logic [CFG_DATA_W-1:0] low, input logic [CFG_DATA_W-1:0] high);
    write_reg(REG_COEF_LOW, low);
    write_reg(REG_COEF_HIGH, high);
    write_reg(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, REG_COEF_HIGH + 1)),
              {$urandom, $urandom});
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_state();
    send_sample(8'hff, 1'b0);
    send_sample(8'h01, 1'b1);
  endtask

  task automatic test_bad_index();
    int unsigned idx;
    wait_drained();
    for (idx = REG_COEF_HIGH + 1; idx < (1 << CFG_IDX_W); idx++) begin
      write_reg(CFG_IDX_W'(idx), '1);
    end
    cfg_valid <= 1'b0;
    send_sample(8'hff, 1'b1);
  endtask

  task automatic test_impulse();
    int n;
    wait_drained();
    load_coefs(64'h80_40_20_10_08_04_02_01, 64'hfe_fd_fb_f7_ef_df_bf_7f);
    send_sample(8'h01, 1'b0);
    for (n = 1; n < MAX_TAPS; n++) begin
      send_sample(8'h00, n == MAX_TAPS - 1);
    end
  endtask

  task automatic test_wraparound();
    wait_drained();
    load_coefs('1, '1);
    send_sample(8'hff, 1'b0);
    send_sample(8'hff, 1'b0);
    send_sample(8'h80, 1'b1);
    // history is empty again after the block end
    send_sample(8'hff, 1'b1);
  endtask

  task automatic test_random_stream();
    int unsigned sent;
    int unsigned phase_end;
    int unsigned run_len;
    int unsigned n;
    logic [CFG_DATA_W-1:0] low;
    logic [CFG_DATA_W-1:0] high;
    logic [SAMPLE_W-1:0] value;
    logic last;
    sent = 0;
    while (sent < RANDOM_SAMPLES) begin
      wait_drained();
      low = {$urandom, $urandom};
      high = {$urandom, $urandom};
      case ($urandom_range(0, 5))
        0: begin
          low = '0;
          high = '0;
        end
        1: begin
          low = '1;
          high = '1;
        end
        2: begin
          low = CFG_DATA_W'(low[COEF_W-1:0]);
          high = '0;
        end
        3: low = '0;
        default: ;
      endcase
      load_coefs(low, high);
      phase_end = sent + PHASE_SAMPLES;
      while (sent < phase_end) begin
        in_gaps = $urandom_range(0, 2) != 0;
        out_stalls = $urandom_range(0, 2) != 0;
        run_len = $urandom_range(0, 7) == 0 ? $urandom_range(1, 3) : $urandom_range(4, 40);
        for (n = 0; n < run_len && sent < phase_end; n++) begin
          case ($urandom_range(0, 9))
            0: value = '0;
            1: value = '1;
            default: value = SAMPLE_W'($urandom);
          endcase
          // a stray block end now and then breaks a block early
          last = (n == run_len - 1) || ($urandom_range(0, 29) == 0);
          send_sample(value, last);
          sent++;
        end
      end
    end
  endtask

  initial begin : result_checker
    out_item_t want;
    int unsigned stall;
    @(posedge clk iff rst_n);
    forever begin
      stall = out_stalls ? $urandom_range(0, 7) : 0;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (filtered_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("unexpected transfer: filtered %02h out_end %0b",
                   out_data.filtered, out_data.out_end);
        end
      end else begin
        want = filtered_q.pop_front();
        if (out_data.filtered !== want.filtered || out_data.out_end !== want.out_end) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("mismatch: filtered exp %02h got %02h, out_end exp %0b got %0b",
                     want.filtered, out_data.filtered, want.out_end, out_data.out_end);
          end
        end
      end
    end
  end

  initial begin
    int unsigned waited;
    coef_words = '{default: '0};
    history = '{default: '0};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_bad_index();
    test_impulse();
    test_wraparound();
    test_random_stream();
    in_valid <= 1'b0;
    for (waited = 0; waited < DRAIN_LIMIT && filtered_q.size() != 0; waited++) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && filtered_q.size() == 0) begin
      $display("[byte_fir_filter] OK");
    end else begin
      $display("[byte_fir_filter] ERROR");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/bff_pkg.sv
rtl/core/bff_tap_cell.sv
rtl/core/bff_out_skid.sv
rtl/core/byte_fir_filter.sv
verif/byte_fir_filter_tb.sv
